[hdl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define HBD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/hbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

  localparam int FRAME_BYTES_MAX_DEF = 65536;
  localparam int CFG_W               = 17;
  localparam int CFG_RESET           = 65536;
  localparam int MIN_FRAME           = 3;
  localparam int QUEUE_DEPTH         = 4;
  localparam int OUT_DATA_W          = 72;

  localparam logic [7:0]  FLAG_BYTE = 8'h7e;
  localparam logic [7:0]  ESC_BYTE  = 8'h7d;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_SEED  = 16'hffff;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_GOOD  = 16'hf0b8;

  typedef enum logic [0:0] {
    REQ_BYTE = 1'b0,
    REQ_EOC  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  // reflected crc-16, one byte, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/hbd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module hbd_front #(
  parameter int FRAME_BYTES_MAX = hbd_pkg::FRAME_BYTES_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [hbd_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,
  input  wire logic [0:0]                 s_tuser,
  input  wire logic                       q_full,
  output hbd_pkg::push_t                  push
);

  localparam int LEN_W       = $clog2(FRAME_BYTES_MAX + 1);
  localparam int RESET_LIMIT = (FRAME_BYTES_MAX < hbd_pkg::CFG_RESET) ?
                               FRAME_BYTES_MAX : hbd_pkg::CFG_RESET;

  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] byte_cnt, byte_cnt_next;
  logic             esc, esc_next;
  logic             drop, drop_next;
  logic [15:0]      crc, crc_next;
  logic [7:0]       hold [2];
  logic [7:0]       hold_next [2];
  logic             accept;
  logic             open_frame;
  logic             bad_close;
  logic [7:0]       ub;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  // limit held already clamped to the legal range
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LEN_W'(RESET_LIMIT);
    end else if (cfg_valid && cfg_ready) begin
      if (32'(cfg_data) > 32'(FRAME_BYTES_MAX)) begin
        limit <= LEN_W'(FRAME_BYTES_MAX);
      end else if (32'(cfg_data) < 32'(hbd_pkg::MIN_FRAME)) begin
        limit <= LEN_W'(hbd_pkg::MIN_FRAME);
      end else begin
        limit <= LEN_W'(cfg_data);
      end
    end
  end

  assign open_frame = (byte_cnt != '0) || esc || drop;
  assign bad_close  = drop || esc || ((byte_cnt != '0) &&
                      ((byte_cnt < LEN_W'(hbd_pkg::MIN_FRAME)) ||
                       (crc != hbd_pkg::CRC_GOOD)));
  assign ub = esc ? (s_tdata ^ hbd_pkg::ESC_XOR) : s_tdata;

  always_comb begin
    byte_cnt_next  = byte_cnt;
    esc_next       = esc;
    drop_next      = drop;
    crc_next       = crc;
    hold_next[0]   = hold[0];
    hold_next[1]   = hold[1];
    push.valid     = 1'b0;
    push.item.kind = hbd_pkg::KIND_PAYLOAD;
    push.item.data = 8'h00;
    if (accept) begin
      if (s_tuser == hbd_pkg::REQ_EOC) begin
        byte_cnt_next  = '0;
        esc_next       = 1'b0;
        drop_next      = 1'b0;
        crc_next       = hbd_pkg::CRC_SEED;
        push.valid     = open_frame;
        push.item.kind = hbd_pkg::KIND_BAD;
      end else if (s_tdata == hbd_pkg::FLAG_BYTE) begin
        byte_cnt_next  = '0;
        esc_next       = 1'b0;
        drop_next      = 1'b0;
        crc_next       = hbd_pkg::CRC_SEED;
        if (bad_close) begin
          push.valid     = 1'b1;
          push.item.kind = hbd_pkg::KIND_BAD;
        end else if (byte_cnt != '0) begin
          push.valid     = 1'b1;
          push.item.kind = hbd_pkg::KIND_GOOD;
        end
      end else if (!drop) begin
        if (!esc && (s_tdata == hbd_pkg::ESC_BYTE)) begin
          esc_next = 1'b1;
        end else begin
          esc_next = 1'b0;
          if (byte_cnt >= limit) begin
            drop_next = 1'b1;
          end else begin
            crc_next      = hbd_pkg::crc_byte(crc, ub);
            byte_cnt_next = byte_cnt + LEN_W'(1);
            if (byte_cnt >= LEN_W'(2)) begin
              // oldest held byte leaves, the two newest stay back as fcs candidates
              push.valid     = 1'b1;
              push.item.data = hold[0];
              hold_next[0]   = hold[1];
              hold_next[1]   = ub;
            end else if (byte_cnt[0]) begin
              hold_next[1] = ub;
            end else begin
              hold_next[0] = ub;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= '0;
      esc      <= 1'b0;
      drop     <= 1'b0;
      crc      <= hbd_pkg::CRC_SEED;
    end else begin
      byte_cnt <= byte_cnt_next;
      esc      <= esc_next;
      drop     <= drop_next;
      crc      <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    hold[0] <= hold_next[0];
    hold[1] <= hold_next[1];
  end

endmodule

`default_nettype wire

[hdl/hbd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module hbd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hbd_pkg::push_t push,
  output logic                full,
  output logic                not_empty,
  output hbd_pkg::item_t      head,
  input  wire logic           pop
);

  localparam int DEPTH = hbd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hbd_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/hbd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module hbd_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  wire hbd_pkg::item_t                   q_head,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [hbd_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic [1:0]                            m_tuser,
  output logic                                  m_tlast
);

  logic [31:0]    good_count, good_count_next;
  logic [31:0]    bad_count, bad_count_next;
  logic [7:0]     data_out;
  hbd_pkg::kind_t kind_out;

  // output register refills whenever it is empty or being drained
  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    good_count_next = good_count;
    bad_count_next  = bad_count;
    case (q_head.kind)
      hbd_pkg::KIND_GOOD: good_count_next = good_count + 32'd1;
      hbd_pkg::KIND_BAD:  bad_count_next  = bad_count + 32'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      good_count <= '0;
      bad_count  <= '0;
    end else begin
      if (q_pop) begin
        m_tvalid   <= 1'b1;
        good_count <= good_count_next;
        bad_count  <= bad_count_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_out <= q_head.data;
      kind_out <= q_head.kind;
    end
  end

  assign m_tdata = {bad_count, good_count, data_out};
  assign m_tuser = kind_out;
  assign m_tlast = (kind_out != hbd_pkg::KIND_PAYLOAD);

endmodule

`default_nettype wire

[hdl/hdlc_byte_deframer_fcs_check.sv]
// channel | dir | handshake          | content
// s       | in  | s_tvalid/s_tready  | tdata: data_byte; tuser: req_type
// m       | out | m_tvalid/m_tready  | tdata: payload, good, malformed; tuser: kind; tlast
// cfg     | in  | cfg_valid/cfg_ready| cfg_data: max_frame_bytes (17 bits)
//
// one item per cycle sustained while the queue is not full; the queue is written on
// the edge that takes an item, and the output register loads from its head when free
// the whole byte step (unescape, crc-16 over 8 bits, holdback) is combinational
// a four-entry queue lets the input keep going while the output stalls
// synchronous reset, no clearing pass; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module hdlc_byte_deframer_fcs_check #(
  parameter int FRAME_BYTES_MAX = hbd_pkg::FRAME_BYTES_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hbd_pkg::CFG_W-1:0]        cfg_data,   // max_frame_bytes
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,    // data_byte
  input  wire logic [0:0]                       s_tuser,    // req_type
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // payload_byte [7:0], good_frames [39:8], malformed_frames [71:40]
  output logic [hbd_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic [1:0]                            m_tuser,    // item_kind
  output logic                                  m_tlast     // last
);

  hbd_pkg::push_t push;
  hbd_pkg::item_t q_head;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;

  hbd_front #(
    .FRAME_BYTES_MAX (FRAME_BYTES_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push)
  );

  hbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  hbd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

[hdl/hbd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hbd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [hbd_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [1:0]                m_tuser,
  input wire logic                      m_tlast
);

  `HBD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output item changed while stalled")
  `HBD_ASSERT(a_last_kind, m_tvalid |-> (m_tlast == (m_tuser != hbd_pkg::KIND_PAYLOAD)), "tlast disagrees with item kind")
  `HBD_ASSERT(a_end_zero, m_tvalid && m_tlast |-> (m_tdata[7:0] == 8'h00), "end item carries a payload byte")
  `HBD_ASSERT_RST(a_rst_idle, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind hdlc_byte_deframer_fcs_check hbd_checker u_hbd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import hbd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    FLAW_NONE,
    FLAW_FCS,
    FLAW_ESC_END,
    FLAW_EOC_END
  } flaw_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] good;
    logic [31:0] bad;
  } deframe_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // data_byte
  logic [0:0]            s_tuser;   // req_type
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // payload_byte, good_frames, malformed_frames
  logic [1:0]            m_tuser;   // item_kind
  logic                  m_tlast;

  hdlc_byte_deframer_fcs_check u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // deframer state as the block should hold it
  logic [CFG_W-1:0] max_bytes = CFG_RESET;
  int unsigned      frm_len   = 0;
  bit               esc_pend  = 1'b0;
  bit               dropping  = 1'b0;
  logic [15:0]      fcs_crc   = CRC_SEED;
  logic [7:0]       hold_buf [2];
  logic [31:0]      n_good    = '0;
  logic [31:0]      n_bad     = '0;

  deframe_result_t pending_results[$];

  int   snd_idle    = 0;
  int   rcv_idle    = 0;
  int   items_sent  = 0;
  int   results_ok  = 0;
  int   cfg_writes  = 0;
  int   errors      = 0;
  logic hold_off;
  event hold_off_go;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_frame();
    frm_len  = 0;
    esc_pend = 1'b0;
    dropping = 1'b0;
    fcs_crc  = CRC_SEED;
  endfunction

  function automatic void queue_result(input kind_t kind, input logic [7:0] data);
    deframe_result_t r;
    r.kind = kind;
    r.data = data;
    r.last = (kind != KIND_PAYLOAD);
    r.good = n_good;
    r.bad  = n_bad;
    pending_results.push_back(r);
  endfunction

  function automatic void deframe_predict(input req_t rq, input logic [7:0] raw);
    logic [7:0]  b;
    bit          was_open;
    bit          bad_end;
    int unsigned lim;
    b        = raw;
    was_open = (frm_len != 0) || esc_pend || dropping;
    lim      = max_bytes;
    if (lim > FRAME_BYTES_MAX_DEF) lim = FRAME_BYTES_MAX_DEF;
    if (lim < MIN_FRAME) lim = MIN_FRAME;
    if (rq == REQ_EOC) begin
      clear_frame();
      if (was_open) begin
        n_bad++;
        queue_result(KIND_BAD, 8'h00);
      end
    end else if (b == FLAG_BYTE) begin
      bad_end = dropping || esc_pend ||
                (frm_len != 0 && (frm_len < MIN_FRAME || fcs_crc != CRC_GOOD));
      if (bad_end) begin
        n_bad++;
        queue_result(KIND_BAD, 8'h00);
      end else if (frm_len != 0) begin
        n_good++;
        queue_result(KIND_GOOD, 8'h00);
      end
      clear_frame();
    end else if (!dropping) begin
      if (!esc_pend && b == ESC_BYTE) begin
        esc_pend = 1'b1;
      end else begin
        if (esc_pend) b = b ^ ESC_XOR;
        esc_pend = 1'b0;
        if (frm_len >= lim) begin
          dropping = 1'b1;
        end else begin
          fcs_crc = crc16_update(fcs_crc, b);
          // two-byte holdback keeps the fcs from being passed on
          if (frm_len >= 2) begin
            queue_result(KIND_PAYLOAD, hold_buf[0]);
            hold_buf[0] = hold_buf[1];
            hold_buf[1] = b;
          end else begin
            hold_buf[frm_len] = b;
          end
          frm_len++;
        end
      end
    end
  endfunction

  task automatic send_item(input req_t rq, input logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= rq;
    do @(posedge clk); while (!s_tready);
    deframe_predict(rq, b);
    items_sent++;
  endtask

  // escapes flag and escape bytes, and now and then an ordinary one
  task automatic send_wire(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(15) == 0) begin
      send_item(REQ_BYTE, ESC_BYTE);
      send_item(REQ_BYTE, b ^ ESC_XOR);
    end else begin
      send_item(REQ_BYTE, b);
    end
  endtask

  task automatic send_frame(input byte_q_t pay, input flaw_t flaw);
    byte_q_t     body;
    logic [15:0] c;
    int          k;
    body = pay;
    c    = CRC_SEED;
    foreach (pay[i]) c = crc16_update(c, pay[i]);
    c = ~c;
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    if (flaw == FLAW_FCS) begin
      k = $urandom_range(body.size() - 1);
      body[k] = body[k] ^ (8'h01 << $urandom_range(7));
    end
    foreach (body[i]) send_wire(body[i]);
    case (flaw)
      FLAW_ESC_END: begin
        send_item(REQ_BYTE, ESC_BYTE);
        send_item(REQ_BYTE, FLAG_BYTE);
      end
      FLAW_EOC_END: send_item(REQ_EOC, 8'($urandom));
      default: send_item(REQ_BYTE, FLAG_BYTE);
    endcase
  endtask

  function automatic byte_q_t random_payload(input int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) q.push_back($urandom_range(1) ? FLAG_BYTE : ESC_BYTE);
      else q.push_back(8'($urandom));
    end
    return q;
  endfunction

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_bytes = v;
    cfg_writes++;
  endtask

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    deframe_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: kind %0d, tdata %0h", m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("item_kind", want.kind, m_tuser);
        check_field("payload_byte", want.data, m_tdata[7:0]);
        check_field("last", want.last, m_tlast);
        check_field("good_frames", want.good, m_tdata[39:8]);
        check_field("malformed_frames", want.bad, m_tdata[71:40]);
        results_ok++;
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_off = 1'b0;
    forever begin
      @(hold_off_go);
      hold_off <= 1'b1;
      repeat (80) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic test_frame_basics();
    send_item(REQ_BYTE, FLAG_BYTE);           // idle flag, no item out
    send_frame('{8'h00}, FLAW_NONE);
    send_frame('{FLAG_BYTE, ESC_BYTE}, FLAW_NONE);
    wait_drain();
  endtask

  task automatic test_frame_errors();
    send_item(REQ_BYTE, 8'hff);               // runt
    send_item(REQ_BYTE, FLAG_BYTE);
    send_item(REQ_BYTE, ESC_BYTE);            // escape right before the flag
    send_item(REQ_BYTE, FLAG_BYTE);
    send_item(REQ_BYTE, 8'h55);               // frame cut by end of capture
    send_item(REQ_EOC, 8'hff);
    send_item(REQ_EOC, 8'h00);                // nothing open
    send_item(REQ_BYTE, ESC_BYTE);
    send_item(REQ_EOC, 8'h7e);
    send_frame('{8'h12, 8'h34}, FLAW_FCS);
    wait_drain();
  endtask

  task automatic test_frame_limit();
    write_limit('0);                          // saturates up to the minimum
    for (int i = 1; i <= 4; i++) send_item(REQ_BYTE, 8'(i));
    send_item(REQ_BYTE, FLAG_BYTE);
    wait_drain();
    write_limit('1);
    send_frame(random_payload(5), FLAW_NONE);
    for (int i = 1; i <= 5; i++) send_item(REQ_BYTE, 8'(i));
    wait_drain();
    write_limit(17'd4);                       // lowered below the open frame
    send_item(REQ_BYTE, 8'h06);
    send_item(REQ_BYTE, FLAG_BYTE);
    wait_drain();
    write_limit(17'd3);
    send_frame('{8'ha5}, FLAW_NONE);
    wait_drain();
    write_limit(CFG_RESET);
  endtask

  task automatic test_back_pressure();
    snd_idle = 0;
    rcv_idle = 0;
    -> hold_off_go;
    send_frame(random_payload(30), FLAW_NONE);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int snd, input int rcv, input int n_items);
    int      stop_at;
    int      next_cfg;
    int      r;
    byte_q_t pay;
    snd_idle = snd;
    rcv_idle = rcv;
    stop_at  = items_sent + n_items;
    next_cfg = items_sent + 180;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        wait_drain();
        case ($urandom_range(3))
          0: write_limit(17'($urandom_range(3, 24)));
          1: write_limit(CFG_RESET);
          2: write_limit(17'($urandom));
          default: write_limit(17'($urandom_range(0, 2)));
        endcase
        next_cfg = items_sent + 180;
      end
      r = $urandom_range(99);
      if (r < 60) begin
        pay = random_payload(($urandom_range(19) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 14));
        send_frame(pay, FLAW_NONE);
      end else if (r < 78) begin
        send_frame(random_payload($urandom_range(0, 10)), flaw_t'($urandom_range(1, 3)));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 6)) begin
          pay = random_payload(1);
          send_item(REQ_BYTE, pay[0]);
        end
      end else if (r < 94) begin
        send_item(REQ_EOC, 8'($urandom));
      end else begin
        send_item(REQ_BYTE, FLAG_BYTE);
      end
    end
    wait_drain();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_frame_basics();
    test_frame_errors();
    test_frame_limit();
    test_back_pressure();
    test_random_traffic(19, 54, 530);
    test_random_traffic(54, 19, 530);
    test_random_traffic(0, 0, 530);
    $display("sent %0d items, checked %0d results, %0d limit writes",
             items_sent, results_ok, cfg_writes);
    $display("frames closed: %0d good, %0d malformed", n_good, n_bad);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
